// ----- src/bsa_pkg.sv -----
// Shared types and constants for the buddy segment allocator.
package bsa_pkg;

    localparam int ORDER_CAP = 10;
    localparam int SEG_W     = ORDER_CAP;
    localparam int ORD_W     = $clog2(ORDER_CAP + 1);
    localparam int LVL_W     = $clog2(ORDER_CAP + 2);
    localparam int MAP_AW    = ORDER_CAP + 1;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [ORD_W-1:0] block_order;
        logic [SEG_W-1:0] segment;
    } t_req;

    typedef struct packed {
        logic             status;
        logic [SEG_W-1:0] first_segment;
    } t_rsp;

    typedef struct packed {
        logic idle;
        logic done;
    } t_ctl_status;

endpackage

// ----- src/bsa_map_mem.sv -----
// Single-port free bitmap memory, registered read.
module bsa_map_mem #(
    parameter int AW = bsa_pkg::MAP_AW
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic          i_wdata,
    output logic          o_rdata
);
    logic r_mem [0:(2**AW)-1];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/bsa_ctrl.sv -----
// Allocate/free sequencer: bitmap scan, split, merge and free counts.
module bsa_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_init,
    input  logic [bsa_pkg::LVL_W-1:0] i_max,
    input  logic                      i_start,
    input  bsa_pkg::t_req             i_req,
    input  logic                      i_ready,
    output bsa_pkg::t_ctl_status      o_status,
    output bsa_pkg::t_rsp             o_rsp
);
    import bsa_pkg::*;

    localparam int AW = MAP_AW;
    localparam int IW = ORDER_CAP;
    localparam int CW = ORDER_CAP + 1;
    localparam int OW = LVL_W;
    localparam int CD = 2 ** OW;

    typedef enum logic [8:0] {
        S_CLR   = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_ASCAN = 9'b000000100,
        S_ARD   = 9'b000001000,
        S_ACHK  = 9'b000010000,
        S_ASPL  = 9'b000100000,
        S_FRD   = 9'b001000000,
        S_FCHK  = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    logic [OW-1:0] r_o, n_o, r_ord, n_ord;
    logic [IW-1:0] r_idx, n_idx, r_i, n_i;
    logic          r_mode, n_mode, r_fail, n_fail;
    logic [CW-1:0] r_cnt [0:CD-1];

    logic          mem_we, mem_wd, mem_rd;
    logic [AW-1:0] mem_addr;
    logic          cnt_we, cnt_inc;
    logic [OW-1:0] cnt_idx;
    logic [31:0]   seg_t, last_t;

    function automatic logic [AW-1:0] base_of(input logic [OW-1:0] o);
        base_of = AW'((32'd1 << AW) - (32'd1 << (ORDER_CAP - int'(o) + 1)));
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [OW-1:0] o,
                                              input logic [IW-1:0] i);
        addr_of = base_of(o) + AW'(i);
    endfunction

    bsa_map_mem #(.AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wd),
        .o_rdata (mem_rd)
    );

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_o      = r_o;
        n_ord    = r_ord;
        n_idx    = r_idx;
        n_i      = r_i;
        n_mode   = r_mode;
        n_fail   = r_fail;
        mem_we   = 1'b0;
        mem_wd   = 1'b0;
        mem_addr = r_clr;
        cnt_we   = 1'b0;
        cnt_inc  = 1'b0;
        cnt_idx  = r_o;
        seg_t    = 32'(i_req.segment) >> i_req.block_order;
        last_t   = (32'd1 << (int'(i_max) - int'(r_o))) - 32'd1;
        unique case (r_state)
            S_CLR: begin
                mem_we = 1'b1;
                mem_wd = (r_clr == base_of(i_max));
                n_clr  = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_mode = i_req.mode;
                    n_o    = OW'(i_req.block_order);
                    n_ord  = OW'(i_req.block_order);
                    n_fail = 1'b0;
                    n_idx  = IW'(seg_t & ((32'd1 << (int'(i_max)
                             - int'(i_req.block_order))) - 32'd1));
                    if (int'(i_req.block_order) > int'(i_max)) begin
                        n_fail  = (i_req.mode == MODE_ALLOC);
                        n_state = S_DONE;
                    end else if (i_req.mode == MODE_ALLOC) begin
                        n_state = S_ASCAN;
                    end else begin
                        n_state = S_FRD;
                    end
                end
            end
            S_ASCAN: begin
                n_i = '0;
                if (r_o > i_max) begin
                    n_fail  = 1'b1;
                    n_state = S_DONE;
                end else if (r_cnt[r_o] != '0) begin
                    n_state = S_ARD;
                end else begin
                    n_o = r_o + 1'b1;
                end
            end
            S_ARD: begin
                mem_addr = addr_of(r_o, r_i);
                n_state  = S_ACHK;
            end
            S_ACHK: begin
                mem_addr = addr_of(r_o, r_i);
                if (mem_rd) begin
                    mem_we  = 1'b1;
                    mem_wd  = 1'b0;
                    cnt_we  = 1'b1;
                    n_idx   = r_i;
                    n_state = (r_o == r_ord) ? S_DONE : S_ASPL;
                end else if (r_i == IW'(last_t)) begin
                    n_o     = r_o + 1'b1;
                    n_state = S_ASCAN;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_ARD;
                end
            end
            S_ASPL: begin
                n_o      = r_o - 1'b1;
                n_idx    = {r_idx[IW-2:0], 1'b0};
                mem_addr = addr_of(n_o, n_idx ^ IW'(1));
                mem_we   = 1'b1;
                mem_wd   = 1'b1;
                cnt_we   = 1'b1;
                cnt_inc  = 1'b1;
                cnt_idx  = n_o;
                if (n_o == r_ord) begin
                    n_state = S_DONE;
                end
            end
            S_FRD: begin
                if (r_o < i_max) begin
                    mem_addr = addr_of(r_o, r_idx ^ IW'(1));
                    n_state  = S_FCHK;
                end else begin
                    mem_addr = addr_of(r_o, r_idx);
                    mem_we   = 1'b1;
                    mem_wd   = 1'b1;
                    cnt_we   = 1'b1;
                    cnt_inc  = 1'b1;
                    n_state  = S_DONE;
                end
            end
            S_FCHK: begin
                mem_we  = 1'b1;
                cnt_we  = 1'b1;
                if (mem_rd) begin
                    mem_addr = addr_of(r_o, r_idx ^ IW'(1));
                    mem_wd   = 1'b0;
                    n_idx    = r_idx >> 1;
                    n_o      = r_o + 1'b1;
                    n_state  = S_FRD;
                end else begin
                    mem_addr = addr_of(r_o, r_idx);
                    mem_wd   = 1'b1;
                    cnt_inc  = 1'b1;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (i_init) begin
            n_state = S_CLR;
            n_clr   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
        r_o    <= n_o;
        r_ord  <= n_ord;
        r_idx  <= n_idx;
        r_i    <= n_i;
        r_mode <= n_mode;
        r_fail <= n_fail;
        for (int k = 0; k < CD; k++) begin
            if (r_state == S_CLR) begin
                r_cnt[k] <= (OW'(k) == i_max) ? CW'(1) : '0;
            end else if (cnt_we && cnt_idx == OW'(k)) begin
                r_cnt[k] <= cnt_inc ? r_cnt[k] + 1'b1 : r_cnt[k] - 1'b1;
            end
        end
    end

    assign o_status.idle = (r_state == S_IDLE);
    assign o_status.done = (r_state == S_DONE) && i_ready;
    assign o_rsp.status  = r_fail;
    assign o_rsp.first_segment = (r_fail || r_mode == MODE_FREE) ? '0 :
                                 SEG_W'(32'(r_idx) << r_ord);
endmodule

// ----- src/buddy_segment_allocator.sv -----
// Buddy segment allocator top level: configuration and result register.
// Input channel carries one request (allocate or free) per transaction;
// o_in_stall is high while a request is in progress or the map is cleared.
// Requests are handled one at a time by a sequencer round a single-port
// free bitmap memory with registered read.
// Allocate: scans bitmap bits from the requested order up (up to
// 2^(M-o) bits per order with a nonzero count; orders with a zero count
// are passed over), then splits one level at a time to the requested order.
// Free: merges with the free buddy level by level, then checks the last
// buddy and sets the block, or only sets it when it has reached the top order.
// Result appears in an output register; a new request is accepted while
// the result waits. While i_out_stall is high the result holds and the
// sequencer waits in its final state before taking the next request.
// Reset, and any write to the order register, start a clearing pass
// that rebuilds the map to one free top block; no request is accepted
// during it.
module buddy_segment_allocator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [bsa_pkg::ORD_W-1:0] i_cfg_wdata,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  bsa_pkg::t_req             i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output bsa_pkg::t_rsp             o_out_data
);
    import bsa_pkg::*;

    logic [LVL_W-1:0] r_max;
    logic             r_out_valid;
    t_rsp             r_out_data;
    logic             ready;
    t_ctl_status      ctl_st;
    t_rsp             ctl_rsp;

    assign ready = !r_out_valid || !i_out_stall;

    bsa_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_init   (i_cfg_we),
        .i_max    (r_max),
        .i_start  (i_in_valid && ctl_st.idle),
        .i_req    (i_in_data),
        .i_ready  (ready),
        .o_status (ctl_st),
        .o_rsp    (ctl_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max       <= LVL_W'((10 > ORDER_CAP) ? ORDER_CAP : 10);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max <= (int'(i_cfg_wdata) > ORDER_CAP) ? LVL_W'(ORDER_CAP)
                                                         : LVL_W'(i_cfg_wdata);
            end
            if (ctl_st.done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (ctl_st.done) begin
            r_out_data <= ctl_rsp;
        end
    end

    assign o_in_stall  = !ctl_st.idle;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
endmodule

// ----- src/bsa_checker.sv -----
// Port-level checks for the buddy segment allocator, bound to the top.
module bsa_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_cfg_we,
    input logic          o_in_stall,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input bsa_pkg::t_rsp o_out_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("request accepted during clearing after reset");

    a_cfg_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> o_in_stall)
        else $error("request accepted during clearing after config write");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status |-> o_out_data.first_segment == '0)
        else $error("failed transaction carries a segment");
endmodule

bind buddy_segment_allocator bsa_checker u_bsa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
